// ===== src/tsp_pkg.sv =====
// Shared types and constants of the traffic signal preemption controller.
package tsp_pkg;

	localparam int unsigned NUM_LANES = 3;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		CFG_MASTER_UID   = 3'd0,
		CFG_GREEN_SEC    = 3'd1,
		CFG_HOLD_TICKS   = 3'd2,
		CFG_EXTEND_SEC   = 3'd3,
		CFG_MAX_EXT      = 3'd4,
		CFG_PREEMPT_CAP  = 3'd5,
		CFG_TICKS_PER_S  = 3'd6
	} cfg_idx_t;

	// Register reset values
	localparam logic [31:0] RST_MASTER_UID  = 32'h596E_795A;
	localparam logic [7:0]  RST_GREEN_SEC   = 8'd10;
	localparam logic [15:0] RST_HOLD_TICKS  = 16'd4000;
	localparam logic [7:0]  RST_EXTEND_SEC  = 8'd4;
	localparam logic [3:0]  RST_MAX_EXT     = 4'd3;
	localparam logic [7:0]  RST_PREEMPT_CAP = 8'd3;
	localparam logic [15:0] RST_TICKS_PER_S = 16'd1000;

	// Tag check codes
	localparam logic [1:0] TAG_NONE    = 2'd0;
	localparam logic [1:0] TAG_MATCH   = 2'd1;
	localparam logic [1:0] TAG_UNKNOWN = 2'd2;

	// Lamp patterns of one green lane
	localparam logic [2:0] LAMP_LANE1 = 3'b001;
	localparam logic [2:0] LAMP_LANE2 = 3'b010;
	localparam logic [2:0] LAMP_LANE3 = 3'b100;

	localparam logic [15:0] HOLD_MAX = 16'hFFFF;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;
	localparam logic [7:0]  SEC_MAX  = 8'hFF;
	localparam logic [3:0]  EXT_MAX  = 4'hF;

	typedef struct packed {
		logic [31:0] master_uid;
		logic [7:0]  green_seconds;
		logic [15:0] hold_ticks;
		logic [7:0]  extend_seconds;
		logic [3:0]  max_extensions;
		logic [7:0]  preempt_cap;
		logic [15:0] ticks_per_second;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  sensor_levels;
		logic        tag_seen;
		logic [31:0] tag_uid;
	} req_t;

	typedef struct packed {
		logic [2:0] green_lamps;
		logic [2:0] red_lamps;
		logic [1:0] active_lane;
		logic [7:0] seconds_left;
		logic [3:0] extensions_used;
		logic       preempt_active;
		logic [1:0] tag_result;
		logic       second_update;
	} rsp_t;

endpackage

// ===== src/tsp_if.sv =====
// Request and result channel interfaces of the signal controller.
interface tsp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  sensor_levels;
	logic        tag_seen;
	logic [31:0] tag_uid;

	modport source (output valid, output sensor_levels, output tag_seen, output tag_uid,
		input ready);
	modport sink (input valid, input sensor_levels, input tag_seen, input tag_uid,
		output ready);
endinterface

interface tsp_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] green_lamps;
	logic [2:0] red_lamps;
	logic [1:0] active_lane;
	logic [7:0] seconds_left;
	logic [3:0] extensions_used;
	logic       preempt_active;
	logic [1:0] tag_result;
	logic       second_update;

	modport source (output valid, output green_lamps, output red_lamps, output active_lane,
		output seconds_left, output extensions_used, output preempt_active,
		output tag_result, output second_update, input ready);
	modport sink (input valid, input green_lamps, input red_lamps, input active_lane,
		input seconds_left, input extensions_used, input preempt_active,
		input tag_result, input second_update, output ready);
endinterface

// ===== src/traffic_signal_preempt_controller.sv =====
// Top level of the three-lane traffic signal controller with emergency preemption.
//
//   channel   dir  protocol        payload
//   req       in   valid/ready     sensor_levels, tag_seen, tag_uid
//   rsp       out  valid/ready     lamps, active lane, seconds, extensions, preempt, tag
//   cfg       in   write enable    cfg_index, cfg_data
//
// One request per cycle while the result is not stalled; each request passes the
// input register, then the next-state logic into the result register.
// Reset puts lane 1 at the default green time with all lamps dark.
// A stalled result holds the result register; the input register still takes
// a new request while it is empty or the result register is free or being drained.
module traffic_signal_preempt_controller (
	input  logic        clk,
	input  logic        arst_n,
	tsp_req_if.sink     req,
	tsp_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	tsp_pkg::cfg_t cfg;
	tsp_pkg::req_t req_s1;
	tsp_pkg::rsp_t rsp_s2;
	tsp_pkg::rsp_t step_rsp;
	logic          valid_s1;
	logic          valid_s2;
	logic          advance;
	logic          step_en;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign step_en   = valid_s1 && advance;

	tsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.req     (req_s1),
		.cfg     (cfg),
		.rsp     (step_rsp)
	);

	// Capture the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.sensor_levels <= req.sensor_levels;
			req_s1.tag_seen      <= req.tag_seen;
			req_s1.tag_uid       <= req.tag_uid;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			rsp_s2 <= step_rsp;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.green_lamps     = rsp_s2.green_lamps;
	assign rsp.red_lamps       = rsp_s2.red_lamps;
	assign rsp.active_lane     = rsp_s2.active_lane;
	assign rsp.seconds_left    = rsp_s2.seconds_left;
	assign rsp.extensions_used = rsp_s2.extensions_used;
	assign rsp.preempt_active  = rsp_s2.preempt_active;
	assign rsp.tag_result      = rsp_s2.tag_result;
	assign rsp.second_update   = rsp_s2.second_update;

endmodule

// ===== src/tsp_cfg.sv =====
// Configuration register file of the signal controller.
module tsp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output tsp_pkg::cfg_t      cfg
);

	tsp_pkg::cfg_t cfg_q;

	// Write one register; ignore unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_uid       <= tsp_pkg::RST_MASTER_UID;
			cfg_q.green_seconds    <= tsp_pkg::RST_GREEN_SEC;
			cfg_q.hold_ticks       <= tsp_pkg::RST_HOLD_TICKS;
			cfg_q.extend_seconds   <= tsp_pkg::RST_EXTEND_SEC;
			cfg_q.max_extensions   <= tsp_pkg::RST_MAX_EXT;
			cfg_q.preempt_cap      <= tsp_pkg::RST_PREEMPT_CAP;
			cfg_q.ticks_per_second <= tsp_pkg::RST_TICKS_PER_S;
		end else if (cfg_we) begin
			case (tsp_pkg::cfg_idx_t'(cfg_index))
				tsp_pkg::CFG_MASTER_UID:  cfg_q.master_uid       <= cfg_data;
				tsp_pkg::CFG_GREEN_SEC:   cfg_q.green_seconds    <= cfg_data[7:0];
				tsp_pkg::CFG_HOLD_TICKS:  cfg_q.hold_ticks       <= cfg_data[15:0];
				tsp_pkg::CFG_EXTEND_SEC:  cfg_q.extend_seconds   <= cfg_data[7:0];
				tsp_pkg::CFG_MAX_EXT:     cfg_q.max_extensions   <= cfg_data[3:0];
				tsp_pkg::CFG_PREEMPT_CAP: cfg_q.preempt_cap      <= cfg_data[7:0];
				tsp_pkg::CFG_TICKS_PER_S: cfg_q.ticks_per_second <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/tsp_core.sv =====
// Sequencer state and the per-tick next-state and result logic.
module tsp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  tsp_pkg::req_t req,
	input  tsp_pkg::cfg_t cfg,
	output tsp_pkg::rsp_t rsp
);

	logic [7:0]  secs_q    [tsp_pkg::NUM_LANES];
	logic [15:0] elapsed_q [tsp_pkg::NUM_LANES];
	logic [2:0]  armed_q;
	logic [2:0]  granted_q;
	logic [15:0] tick_q;
	logic [3:0]  ext_q;
	logic        pend_q;
	logic        latch_q;
	logic [2:0]  lamp_q;
	logic        lit_q;

	logic [7:0]  secs_d    [tsp_pkg::NUM_LANES];
	logic [15:0] elapsed_d [tsp_pkg::NUM_LANES];
	logic [2:0]  armed_d;
	logic [2:0]  granted_d;
	logic [15:0] tick_d;
	logic [3:0]  ext_d;
	logic        pend_d;
	logic        latch_d;
	logic [2:0]  lamp_d;
	logic        lit_d;
	logic [1:0]  tag_res;
	logic        upd;

	// Advance the sequencer by one tick
	always_comb begin
		logic [8:0] sum;
		logic [1:0] active;
		logic [7:0] left;

		for (int i = 0; i < tsp_pkg::NUM_LANES; i++) begin
			secs_d[i] = secs_q[i];
			elapsed_d[i] = (elapsed_q[i] != tsp_pkg::HOLD_MAX) ? elapsed_q[i] + 16'd1
				: elapsed_q[i];
		end
		armed_d   = armed_q;
		granted_d = granted_q;
		ext_d     = ext_q;
		pend_d    = pend_q;
		latch_d   = latch_q;
		lamp_d    = lamp_q;
		lit_d     = lit_q;
		tag_res   = tsp_pkg::TAG_NONE;
		upd       = 1'b0;
		sum       = '0;
		active    = '0;
		left      = '0;

		// Check the tag; a fresh match starts preemption
		if (req.tag_seen) begin
			if (req.tag_uid == cfg.master_uid) begin
				tag_res = tsp_pkg::TAG_MATCH;
				if (!latch_q) begin
					pend_d = 1'b1;
					elapsed_d[1] = tsp_pkg::HOLD_MAX;
					elapsed_d[2] = tsp_pkg::HOLD_MAX;
				end
				latch_d = 1'b1;
			end else begin
				tag_res = tsp_pkg::TAG_UNKNOWN;
			end
		end

		// Occupancy holds, lanes in order
		for (int i = 0; i < tsp_pkg::NUM_LANES; i++) begin
			if (ext_d < cfg.max_extensions || latch_d) begin
				if (!req.sensor_levels[i] && secs_d[i] != 8'd0) begin
					if (!armed_d[i]) begin
						elapsed_d[i] = '0;
						armed_d[i] = 1'b1;
					end
					if (elapsed_d[i] >= cfg.hold_ticks) begin
						if (!granted_d[i]) begin
							sum = {1'b0, secs_d[i]} + {1'b0, cfg.extend_seconds};
							secs_d[i] = sum[8] ? tsp_pkg::SEC_MAX : sum[7:0];
							if (ext_d != tsp_pkg::EXT_MAX) begin
								ext_d = ext_d + 4'd1;
							end
							granted_d[i] = 1'b1;
							armed_d[i] = 1'b0;
						end
					end else begin
						granted_d[i] = 1'b0;
					end
				end else begin
					armed_d[i] = 1'b0;
				end
			end
		end

		// Count ticks toward the next second
		tick_d = (tick_q != tsp_pkg::TICK_MAX) ? tick_q + 16'd1 : tick_q;
		if (tick_d >= cfg.ticks_per_second) begin
			tick_d = '0;
			upd = 1'b1;

			// Lane 1
			if (secs_d[0] != 8'd0) begin
				lamp_d = tsp_pkg::LAMP_LANE1;
				lit_d = 1'b1;
				secs_d[0] = secs_d[0] - 8'd1;
				if (secs_d[0] == 8'd0) begin
					latch_d = 1'b0;
					secs_d[1] = cfg.green_seconds;
					ext_d = '0;
				end
			end
			// Lane 2, capped under preemption
			if (secs_d[1] != 8'd0) begin
				lamp_d = tsp_pkg::LAMP_LANE2;
				lit_d = 1'b1;
				secs_d[1] = secs_d[1] - 8'd1;
				if (pend_d && secs_d[1] > cfg.preempt_cap) begin
					secs_d[1] = cfg.preempt_cap;
					pend_d = 1'b0;
				end
				if (secs_d[1] == 8'd0) begin
					ext_d = '0;
					if (latch_d) begin
						secs_d[0] = cfg.green_seconds;
					end else begin
						secs_d[2] = cfg.green_seconds;
					end
				end
			end
			// Lane 3, capped under preemption
			if (secs_d[2] != 8'd0) begin
				lamp_d = tsp_pkg::LAMP_LANE3;
				lit_d = 1'b1;
				secs_d[2] = secs_d[2] - 8'd1;
				if (pend_d && secs_d[2] > cfg.preempt_cap) begin
					secs_d[2] = cfg.preempt_cap;
					pend_d = 1'b0;
				end
				if (secs_d[2] == 8'd0) begin
					ext_d = '0;
					secs_d[0] = cfg.green_seconds;
				end
			end
		end

		// Decode the lit lane
		case (lamp_d)
			tsp_pkg::LAMP_LANE1: begin
				active = 2'd1;
				left = secs_d[0];
			end
			tsp_pkg::LAMP_LANE2: begin
				active = 2'd2;
				left = secs_d[1];
			end
			tsp_pkg::LAMP_LANE3: begin
				active = 2'd3;
				left = secs_d[2];
			end
			default: begin
				active = 2'd0;
				left = 8'd0;
			end
		endcase

		rsp.green_lamps     = lamp_d;
		rsp.red_lamps       = lit_d ? ~lamp_d : 3'b000;
		rsp.active_lane     = active;
		rsp.seconds_left    = left;
		rsp.extensions_used = ext_d;
		rsp.preempt_active  = latch_d;
		rsp.tag_result      = tag_res;
		rsp.second_update   = upd;
	end

	// Hold state between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_q[0] <= tsp_pkg::RST_GREEN_SEC;
			secs_q[1] <= '0;
			secs_q[2] <= '0;
			for (int i = 0; i < tsp_pkg::NUM_LANES; i++) begin
				elapsed_q[i] <= '0;
			end
			armed_q   <= '0;
			granted_q <= '0;
			tick_q    <= '0;
			ext_q     <= '0;
			pend_q    <= 1'b0;
			latch_q   <= 1'b0;
			lamp_q    <= '0;
			lit_q     <= 1'b0;
		end else if (step_en) begin
			for (int i = 0; i < tsp_pkg::NUM_LANES; i++) begin
				secs_q[i]    <= secs_d[i];
				elapsed_q[i] <= elapsed_d[i];
			end
			armed_q   <= armed_d;
			granted_q <= granted_d;
			tick_q    <= tick_d;
			ext_q     <= ext_d;
			pend_q    <= pend_d;
			latch_q   <= latch_d;
			lamp_q    <= lamp_d;
			lit_q     <= lit_d;
		end
	end

	// At most one green lamp at any time
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(lamp_q))
		else $error("more than one green lamp lit");

	// No green lamp before the lamps are first lit
	assert property (@(posedge clk) disable iff (!arst_n) !lit_q |-> lamp_q == 3'b000)
		else $error("green lamp set while lamps unlit");

	// A second update restarts the tick count
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && upd |=> tick_q == 16'd0)
		else $error("tick count not cleared after second update");

	// State holds when no request is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(tick_q) && $stable(lamp_q) && $stable(ext_q))
		else $error("state changed without a request");

endmodule
